// ===== src/sct_pkg.sv =====
// sct_pkg: shared constants and control type for the segment crossing test.
// No dependencies.
package sct_pkg;

  localparam int COORD_FRAC = 8;
  localparam int TOL_W = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

  typedef struct packed {
    logic vld;
    logic rej;
  } ctl_t;

endpackage

// ===== src/sct_front.sv =====
// sct_front: five pipeline stages from coordinates to the first quotient bit of mue.
// Uses sct_pkg.
module sct_front #(
  parameter int CB = 24,
  parameter int FB = 16,
  parameter int DW = CB + 1,
  parameter int AW = 2 * CB + 3,
  parameter int QW = FB + 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [CB-1:0]            in_a_start_x,
  input  logic signed [CB-1:0]            in_a_start_y,
  input  logic signed [CB-1:0]            in_a_end_x,
  input  logic signed [CB-1:0]            in_a_end_y,
  input  logic signed [CB-1:0]            in_b_start_x,
  input  logic signed [CB-1:0]            in_b_start_y,
  input  logic signed [CB-1:0]            in_b_end_x,
  input  logic signed [CB-1:0]            in_b_end_y,
  input  logic [sct_pkg::TOL_W-1:0]       tol,
  input  logic                            adv,
  output sct_pkg::ctl_t                   ctl_o,
  output logic [AW-1:0]                   rem_o,
  output logic [QW-1:0]                   q_o,
  output logic [AW-1:0]                   ad_o,
  output logic                            neg_o,
  output logic signed [DW-1:0]            dsel_o,
  output logic signed [DW-1:0]            v2sel_o,
  output logic signed [DW-1:0]            lden_o
);

  localparam int PW = 2 * DW;
  localparam int XW = DW + sct_pkg::COORD_FRAC;

  logic e1, e2, e3, e4, e5;

  // stage 1: differences
  logic                 s1_vld_r;
  logic signed [DW-1:0] v1x_r, v1y_r, v2x_r, v2y_r, dx_r, dy_r;
  // stage 2: products, axis choice
  sct_pkg::ctl_t        s2_ctl_r;
  logic signed [PW-1:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [DW-1:0] s2_dsel_r, s2_v2sel_r, s2_lden_r;
  // stage 3: divisor and numerator
  sct_pkg::ctl_t        s3_ctl_r;
  logic signed [AW-1:0] div_r, num_r;
  logic signed [DW-1:0] s3_dsel_r, s3_v2sel_r, s3_lden_r;
  // stage 4: magnitudes
  sct_pkg::ctl_t        s4_ctl_r;
  logic [AW-1:0]        s4_ad_r, s4_an_r;
  logic                 s4_neg_r;
  logic signed [DW-1:0] s4_dsel_r, s4_v2sel_r, s4_lden_r;
  // stage 5: range checks, leading quotient bit
  sct_pkg::ctl_t        s5_ctl_r;
  logic [AW-1:0]        s5_rem_r, s5_ad_r;
  logic                 s5_q_r, s5_neg_r;
  logic signed [DW-1:0] s5_dsel_r, s5_v2sel_r, s5_lden_r;

  logic [DW-1:0] mx, my;
  logic          selx, sely;
  logic [AW-1:0] ad_nxt, an_nxt;
  logic          ge1, rej5;

  assign e5 = !s5_ctl_r.vld || adv;
  assign e4 = !s4_ctl_r.vld || e5;
  assign e3 = !s3_ctl_r.vld || e4;
  assign e2 = !s2_ctl_r.vld || e3;
  assign e1 = !s1_vld_r || e2;
  assign in_stall = !e1;

  assign mx   = v1x_r[DW-1] ? (~v1x_r + 1'b1) : v1x_r;
  assign my   = v1y_r[DW-1] ? (~v1y_r + 1'b1) : v1y_r;
  assign selx = {mx, 8'b0} > XW'(tol);
  assign sely = {my, 8'b0} > XW'(tol);

  assign ad_nxt = div_r[AW-1] ? (~div_r + 1'b1) : div_r;
  assign an_nxt = num_r[AW-1] ? (~num_r + 1'b1) : num_r;

  assign ge1  = s4_an_r >= s4_ad_r;
  assign rej5 = s4_ctl_r.rej || (s4_ad_r < AW'(tol)) || (s4_ad_r == '0) ||
                ({1'b0, s4_an_r} >= {s4_ad_r, 1'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      s2_ctl_r.vld <= 1'b0;
      s3_ctl_r.vld <= 1'b0;
      s4_ctl_r.vld <= 1'b0;
      s5_ctl_r.vld <= 1'b0;
    end else begin
      if (e1) s1_vld_r <= in_valid;
      if (e2) s2_ctl_r <= '{vld: s1_vld_r, rej: !selx && !sely};
      if (e3) s3_ctl_r <= s2_ctl_r;
      if (e4) s4_ctl_r <= s3_ctl_r;
      if (e5) s5_ctl_r <= '{vld: s4_ctl_r.vld, rej: rej5};
    end
  end

  always_ff @(posedge clk) begin
    if (e1) begin
      v1x_r <= DW'(in_a_end_x) - DW'(in_a_start_x);
      v1y_r <= DW'(in_a_end_y) - DW'(in_a_start_y);
      v2x_r <= DW'(in_b_end_x) - DW'(in_b_start_x);
      v2y_r <= DW'(in_b_end_y) - DW'(in_b_start_y);
      dx_r  <= DW'(in_b_start_x) - DW'(in_a_start_x);
      dy_r  <= DW'(in_b_start_y) - DW'(in_a_start_y);
    end
    if (e2) begin
      pa_r         <= v2x_r * v1y_r;
      pb_r         <= v2y_r * v1x_r;
      pc_r         <= v1x_r * dy_r;
      pd_r         <= v1y_r * dx_r;
      s2_dsel_r    <= selx ? dx_r : dy_r;
      s2_v2sel_r   <= selx ? v2x_r : v2y_r;
      s2_lden_r    <= selx ? v1x_r : v1y_r;
    end
    if (e3) begin
      div_r        <= AW'(pa_r) - AW'(pb_r);
      num_r        <= AW'(pc_r) - AW'(pd_r);
      s3_dsel_r    <= s2_dsel_r;
      s3_v2sel_r   <= s2_v2sel_r;
      s3_lden_r    <= s2_lden_r;
    end
    if (e4) begin
      s4_ad_r      <= ad_nxt;
      s4_an_r      <= an_nxt;
      s4_neg_r     <= div_r[AW-1] ^ num_r[AW-1];
      s4_dsel_r    <= s3_dsel_r;
      s4_v2sel_r   <= s3_v2sel_r;
      s4_lden_r    <= s3_lden_r;
    end
    if (e5) begin
      s5_rem_r     <= ge1 ? (s4_an_r - s4_ad_r) : s4_an_r;
      s5_q_r       <= ge1;
      s5_ad_r      <= s4_ad_r;
      s5_neg_r     <= s4_neg_r;
      s5_dsel_r    <= s4_dsel_r;
      s5_v2sel_r   <= s4_v2sel_r;
      s5_lden_r    <= s4_lden_r;
    end
  end

  assign ctl_o   = s5_ctl_r;
  assign rem_o   = s5_rem_r;
  assign q_o     = QW'(s5_q_r);
  assign ad_o    = s5_ad_r;
  assign neg_o   = s5_neg_r;
  assign dsel_o  = s5_dsel_r;
  assign v2sel_o = s5_v2sel_r;
  assign lden_o  = s5_lden_r;

endmodule

// ===== src/sct_div_step.sv =====
// sct_div_step: one registered restoring-division step, one quotient bit of mue.
// Uses sct_pkg.
module sct_div_step #(
  parameter int AW = 51,
  parameter int QW = 17,
  parameter int DW = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  output logic                 rdy,
  input  sct_pkg::ctl_t        ctl_i,
  input  logic [AW-1:0]        rem_i,
  input  logic [QW-1:0]        q_i,
  input  logic [AW-1:0]        ad_i,
  input  logic                 neg_i,
  input  logic signed [DW-1:0] dsel_i,
  input  logic signed [DW-1:0] v2sel_i,
  input  logic signed [DW-1:0] lden_i,
  output sct_pkg::ctl_t        ctl_o,
  output logic [AW-1:0]        rem_o,
  output logic [QW-1:0]        q_o,
  output logic [AW-1:0]        ad_o,
  output logic                 neg_o,
  output logic signed [DW-1:0] dsel_o,
  output logic signed [DW-1:0] v2sel_o,
  output logic signed [DW-1:0] lden_o
);

  sct_pkg::ctl_t ctl_r;
  logic [AW:0]   r2, diff;
  logic          ge;

  assign rdy  = !ctl_r.vld || adv;
  assign r2   = {rem_i, 1'b0};
  assign diff = r2 - {1'b0, ad_i};
  assign ge   = r2 >= {1'b0, ad_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (rdy) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      rem_o     <= ge ? diff[AW-1:0] : r2[AW-1:0];
      q_o       <= {q_i[QW-2:0], ge};
      ad_o      <= ad_i;
      neg_o     <= neg_i;
      dsel_o    <= dsel_i;
      v2sel_o   <= v2sel_i;
      lden_o    <= lden_i;
    end
  end

  assign ctl_o = ctl_r;

endmodule

// ===== src/sct_back.sv =====
// sct_back: five pipeline stages from mue to the crossing decision (lambda window).
// Uses sct_pkg.
module sct_back #(
  parameter int CB = 24,
  parameter int FB = 16,
  parameter int DW = CB + 1,
  parameter int QW = FB + 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [sct_pkg::TOL_W-1:0] tol,
  output logic                      rdy,
  input  sct_pkg::ctl_t             ctl_i,
  input  logic [QW-1:0]             q_i,
  input  logic                      neg_i,
  input  logic signed [DW-1:0]      dsel_i,
  input  logic signed [DW-1:0]      v2sel_i,
  input  logic signed [DW-1:0]      lden_i,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_crosses
);

  localparam int TOLW = sct_pkg::TOL_W;
  localparam int MW = FB + 2;
  localparam int TW = ((QW > TOLW) ? QW : TOLW) + 1;
  localparam int UW = ((FB + 3 > 19) ? FB + 3 : 19);
  localparam int LW = ((CB + FB + 6 > CB + 22) ? CB + FB + 6 : CB + 22);
  localparam int PLW = TOLW + DW;
  localparam int PUW = UW + DW + 1;

  logic e1, e2, e3, e4, e5;

  sct_pkg::ctl_t        m1_ctl_r, m2_ctl_r, m3_ctl_r, m4_ctl_r;
  logic                 m5_vld_r, m5_crs_r;
  logic signed [MW-1:0] mue_r;
  logic signed [DW-1:0] m1_dsel_r, m1_v2sel_r, m1_lden_r;
  logic signed [MW+DW-1:0] mv_r;
  logic signed [DW+FB-1:0] dsh_r;
  logic [DW-1:0]        d_r, m3_d_r;
  logic                 m2_sd_r, m3_sd_r;
  logic signed [LW-1:0] n0_r, pl_r, pu_r, n_r, l_r, u_r;

  logic signed [MW-1:0]    mue_nxt;
  logic                    rej1;
  logic signed [MW+DW-1:0] mv_w;
  logic [PLW-1:0]          pl_w;
  logic signed [UW-1:0]    uval, uu;
  logic signed [PUW-1:0]   pu_w;
  logic                    uneg;

  assign e5  = !m5_vld_r || !out_stall;
  assign e4  = !m4_ctl_r.vld || e5;
  assign e3  = !m3_ctl_r.vld || e4;
  assign e2  = !m2_ctl_r.vld || e3;
  assign e1  = !m1_ctl_r.vld || e2;
  assign rdy = e1;

  assign mue_nxt = neg_i ? -$signed({1'b0, q_i}) : $signed({1'b0, q_i});
  assign rej1 = ctl_i.rej ||
                (neg_i ? (TW'(q_i) > TW'(tol))
                       : (TW'(q_i) > ((TW'(1) << FB) + TW'(tol))));

  assign mv_w = mue_r * m1_v2sel_r;

  assign uval = (UW'(1) << FB) - $signed(UW'(tol));
  assign uneg = uval[UW-1];
  assign uu   = uneg ? uval : uval + UW'(1);
  assign pl_w = tol * d_r;
  assign pu_w = uu * $signed({1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_ctl_r.vld <= 1'b0;
      m2_ctl_r.vld <= 1'b0;
      m3_ctl_r.vld <= 1'b0;
      m4_ctl_r.vld <= 1'b0;
      m5_vld_r     <= 1'b0;
    end else begin
      if (e1) m1_ctl_r <= '{vld: ctl_i.vld, rej: rej1};
      if (e2) m2_ctl_r <= m1_ctl_r;
      if (e3) m3_ctl_r <= m2_ctl_r;
      if (e4) m4_ctl_r <= m3_ctl_r;
      if (e5) m5_vld_r <= m4_ctl_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (e1) begin
      mue_r        <= mue_nxt;
      m1_dsel_r    <= dsel_i;
      m1_v2sel_r   <= v2sel_i;
      m1_lden_r    <= lden_i;
    end
    if (e2) begin
      mv_r         <= mv_w;
      dsh_r        <= {m1_dsel_r, FB'(0)};
      d_r          <= m1_lden_r[DW-1] ? (~m1_lden_r + 1'b1) : m1_lden_r;
      m2_sd_r      <= m1_lden_r[DW-1];
    end
    if (e3) begin
      n0_r         <= LW'(dsh_r) + LW'(mv_r);
      pl_r         <= LW'($signed({1'b0, pl_w}));
      pu_r         <= LW'(pu_w);
      m3_d_r       <= d_r;
      m3_sd_r      <= m2_sd_r;
    end
    if (e4) begin
      n_r          <= m3_sd_r ? -n0_r : n0_r;
      l_r          <= (tol != '0) ? pl_r : LW'(1) - LW'($signed({1'b0, m3_d_r}));
      u_r          <= uneg ? pu_r : pu_r - LW'(1);
    end
    if (e5) begin
      m5_crs_r <= !m4_ctl_r.rej && (n_r >= l_r) && (n_r <= u_r);
    end
  end

  assign out_valid   = m5_vld_r;
  assign out_crosses = m5_crs_r;

endmodule

// ===== src/segment_crossing_test_top.sv =====
// Segment crossing test: decides whether two 2D segments cross within a tolerance.
// One item per cycle sustained while out_stall is low.
// Pipeline: 5 setup stages, one mue quotient bit per stage, 5 lambda window stages.
// Each stage holds when its successor is full and stalled; bubbles are absorbed.
// rst_n (synchronous) empties the pipeline and loads tolerance 7.
module segment_crossing_test_top #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sct_pkg::TOL_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_a_start_x,
  input  logic signed [COORD_BITS-1:0]  in_a_start_y,
  input  logic signed [COORD_BITS-1:0]  in_a_end_x,
  input  logic signed [COORD_BITS-1:0]  in_a_end_y,
  input  logic signed [COORD_BITS-1:0]  in_b_start_x,
  input  logic signed [COORD_BITS-1:0]  in_b_start_y,
  input  logic signed [COORD_BITS-1:0]  in_b_end_x,
  input  logic signed [COORD_BITS-1:0]  in_b_end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_crosses
);

  localparam int DW = COORD_BITS + 1;
  localparam int AW = 2 * COORD_BITS + 3;
  localparam int QW = FRAC_BITS + 1;

  logic [sct_pkg::TOL_W-1:0] tol_r;

  sct_pkg::ctl_t        ctl_a   [FRAC_BITS+1];
  logic [AW-1:0]        rem_a   [FRAC_BITS+1];
  logic [QW-1:0]        q_a     [FRAC_BITS+1];
  logic [AW-1:0]        ad_a    [FRAC_BITS+1];
  logic                 neg_a   [FRAC_BITS+1];
  logic signed [DW-1:0] dsel_a  [FRAC_BITS+1];
  logic signed [DW-1:0] v2sel_a [FRAC_BITS+1];
  logic signed [DW-1:0] lden_a  [FRAC_BITS+1];
  logic                 rdy_a   [FRAC_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= sct_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  sct_front #(.CB(COORD_BITS), .FB(FRAC_BITS), .DW(DW), .AW(AW), .QW(QW)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_a_start_x (in_a_start_x),
    .in_a_start_y (in_a_start_y),
    .in_a_end_x   (in_a_end_x),
    .in_a_end_y   (in_a_end_y),
    .in_b_start_x (in_b_start_x),
    .in_b_start_y (in_b_start_y),
    .in_b_end_x   (in_b_end_x),
    .in_b_end_y   (in_b_end_y),
    .tol          (tol_r),
    .adv          (rdy_a[0]),
    .ctl_o        (ctl_a[0]),
    .rem_o        (rem_a[0]),
    .q_o          (q_a[0]),
    .ad_o         (ad_a[0]),
    .neg_o        (neg_a[0]),
    .dsel_o       (dsel_a[0]),
    .v2sel_o      (v2sel_a[0]),
    .lden_o       (lden_a[0])
  );

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    sct_div_step #(.AW(AW), .QW(QW), .DW(DW)) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (rdy_a[i+1]),
      .rdy     (rdy_a[i]),
      .ctl_i   (ctl_a[i]),
      .rem_i   (rem_a[i]),
      .q_i     (q_a[i]),
      .ad_i    (ad_a[i]),
      .neg_i   (neg_a[i]),
      .dsel_i  (dsel_a[i]),
      .v2sel_i (v2sel_a[i]),
      .lden_i  (lden_a[i]),
      .ctl_o   (ctl_a[i+1]),
      .rem_o   (rem_a[i+1]),
      .q_o     (q_a[i+1]),
      .ad_o    (ad_a[i+1]),
      .neg_o   (neg_a[i+1]),
      .dsel_o  (dsel_a[i+1]),
      .v2sel_o (v2sel_a[i+1]),
      .lden_o  (lden_a[i+1])
    );
  end

  sct_back #(.CB(COORD_BITS), .FB(FRAC_BITS), .DW(DW), .QW(QW)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .tol         (tol_r),
    .rdy         (rdy_a[FRAC_BITS]),
    .ctl_i       (ctl_a[FRAC_BITS]),
    .q_i         (q_a[FRAC_BITS]),
    .neg_i       (neg_a[FRAC_BITS]),
    .dsel_i      (dsel_a[FRAC_BITS]),
    .v2sel_i     (v2sel_a[FRAC_BITS]),
    .lden_i      (lden_a[FRAC_BITS]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_crosses (out_crosses)
  );

endmodule

// ===== tb/segment_crossing_test_checker.sv =====
// Checker for segment_crossing_test_top: tracks the tolerance register, predicts the
// crossing flag of each accepted item and compares it with the result stream.
// Depends on sct_pkg.
`timescale 1ns / 100ps
module segment_crossing_test_checker #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [sct_pkg::TOL_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_a_start_x,
  input  logic signed [COORD_BITS-1:0] in_a_start_y,
  input  logic signed [COORD_BITS-1:0] in_a_end_x,
  input  logic signed [COORD_BITS-1:0] in_a_end_y,
  input  logic signed [COORD_BITS-1:0] in_b_start_x,
  input  logic signed [COORD_BITS-1:0] in_b_start_y,
  input  logic signed [COORD_BITS-1:0] in_b_end_x,
  input  logic signed [COORD_BITS-1:0] in_b_end_y,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_crosses,
  output int                           errors,
  output int                           pending,
  output int                           hits
);

  logic [sct_pkg::TOL_W-1:0] tol_q;
  bit                        crossings_due[$];

  function automatic longint abs64(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic bit segments_cross(longint p1x, longint p1y, longint e1x,
                                        longint e1y, longint p2x, longint p2y,
                                        longint e2x, longint e2y, longint tol);
    longint v1x, v1y, v2x, v2y, dx, dy, dvs, ad, num, an, q, rem, mue, lnum, lden;
    longint lambda, one;
    v1x = e1x - p1x;
    v1y = e1y - p1y;
    v2x = e2x - p2x;
    v2y = e2y - p2y;
    dx  = p2x - p1x;
    dy  = p2y - p1y;
    one = longint'(1) <<< FRAC_BITS;
    dvs = v2x * v1y - v2y * v1x;
    ad  = abs64(dvs);
    if (ad < tol || ad == 0) return 1'b0;
    num = v1x * dy - v1y * dx;
    an  = abs64(num);
    if (an >= 2 * ad) return 1'b0;
    q   = an / ad;
    rem = an % ad;
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem <<< 1;
      q   = q <<< 1;
      if (rem >= ad) begin
        rem = rem - ad;
        q   = q | 1;
      end
    end
    mue = ((num < 0) != (dvs < 0)) ? -q : q;
    if (mue < -tol || mue > one + tol) return 1'b0;
    if ((abs64(v1x) <<< sct_pkg::COORD_FRAC) > tol) begin
      lnum = dx * one + mue * v2x;
      lden = v1x;
    end else if ((abs64(v1y) <<< sct_pkg::COORD_FRAC) > tol) begin
      lnum = dy * one + mue * v2y;
      lden = v1y;
    end else begin
      return 1'b0;
    end
    if (lden == 0) return 1'b0;
    lambda = lnum / lden;
    return (lambda >= tol && lambda <= one - tol);
  endfunction

  initial begin
    errors  = 0;
    hits    = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    bit exp_cross;
    if (!rst_n) begin
      tol_q <= sct_pkg::TOL_RESET;
    end else begin
      if (cfg_we) tol_q <= cfg_wdata;
      if (in_valid && !in_stall) begin
        exp_cross = segments_cross(in_a_start_x, in_a_start_y, in_a_end_x, in_a_end_y,
                                   in_b_start_x, in_b_start_y, in_b_end_x, in_b_end_y,
                                   longint'(tol_q));
        crossings_due.push_back(exp_cross);
      end
      if (out_valid && !out_stall) begin
        if (crossings_due.size() == 0) begin
          $error("unexpected result item: crosses=%0b", out_crosses);
          errors++;
        end else begin
          exp_cross = crossings_due.pop_front();
          if (out_crosses !== exp_cross) begin
            $error("field crosses: expected %0b, actual %0b", exp_cross, out_crosses);
            errors++;
          end
          if (exp_cross) hits++;
        end
      end
    end
    pending = crossings_due.size();
  end

endmodule

// ===== tb/segment_crossing_test_top_tb.sv =====
// Testbench top for segment_crossing_test_top: drives segment pairs and tolerance
// settings with random idling on both channels; checking is done by
// segment_crossing_test_checker. Depends on sct_pkg.
`timescale 1ns / 100ps
module segment_crossing_test_top_tb;

  localparam int CW = 24;
  localparam int LATENCY = 26;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [sct_pkg::TOL_W-1:0] cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [CW-1:0]      a_sx = '0, a_sy = '0, a_ex = '0, a_ey = '0;
  logic signed [CW-1:0]      b_sx = '0, b_sy = '0, b_ex = '0, b_ey = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b1;
  logic                      out_crosses;
  int                        errors, pending, hits;
  int                        n_items = 0;
  bit                        calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_crossing_test_top u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a_start_x(a_sx), .in_a_start_y(a_sy), .in_a_end_x(a_ex), .in_a_end_y(a_ey),
    .in_b_start_x(b_sx), .in_b_start_y(b_sy), .in_b_end_x(b_ex), .in_b_end_y(b_ey),
    .out_valid(out_valid), .out_stall(out_stall), .out_crosses(out_crosses)
  );

  segment_crossing_test_checker u_chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a_start_x(a_sx), .in_a_start_y(a_sy), .in_a_end_x(a_ex), .in_a_end_y(a_ey),
    .in_b_start_x(b_sx), .in_b_start_y(b_sy), .in_b_end_x(b_ex), .in_b_end_y(b_ey),
    .out_valid(out_valid), .out_stall(out_stall), .out_crosses(out_crosses),
    .errors(errors), .pending(pending), .hits(hits)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) calm <= !calm;
    if (calm) out_stall <= 1'b0;
    else if ($urandom_range(0, 99) < 3) out_stall <= 1'b1;
    else if (out_stall) out_stall <= ($urandom_range(0, 99) < 70);
    else out_stall <= ($urandom_range(0, 99) < 25);
  end

  task automatic send_pair(input logic [CW-1:0] ax0, ay0, ax1, ay1,
                           input logic [CW-1:0] bx0, by0, bx1, by1);
    int gap;
    in_valid <= 1'b1;
    a_sx <= ax0; a_sy <= ay0; a_ex <= ax1; a_ey <= ay1;
    b_sx <= bx0; b_sy <= by0; b_ex <= bx1; b_ey <= by1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_tolerance(input logic [sct_pkg::TOL_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CW-1:0] near(int base, int span);
    return CW'(base + $signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic random_pairs(input int count);
    int base, span;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 15) begin
        send_pair($urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
      end else begin
        span = 1 << $urandom_range(2, 21);
        base = $signed($urandom_range(0, 8388608)) - 4194304;
        send_pair(near(base, span), near(base, span), near(base, span),
                  near(base, span), near(base, span), near(base, span),
                  near(base, span), near(base, span));
      end
    end
  endtask

  task automatic directed_pairs();
    send_pair(0, 0, 256, 256, 0, 256, 256, 0);
    send_pair(0, 0, 256, 0, 0, 256, 256, 256);
    send_pair(-8388608, -8388608, 8388607, 8388607, -8388608, 8388607, 8388607, -8388608);
    send_pair(8388607, 8388607, -8388608, -8388608, 8388607, -8388608, -8388608, 8388607);
    send_pair(0, 0, 0, 512, -256, 256, 256, 256);
    send_pair(5, 5, 5, 5, -256, 0, 256, 9);
    send_pair(0, 0, 256, 256, 4000, 0, 4001, 3);
    send_pair(0, 0, 256, 0, 256, -256, 256, 256);
    send_pair(0, 0, 256, 0, 0, -256, 0, 256);
    send_pair(0, 0, 256, 0, 512, -256, 512, 256);
    send_pair(-1, -1, 1, 1, -1, 1, 1, -1);
    send_pair(0, 0, 0, 1, -3, 0, 3, 1);
    send_pair(0, 0, 1, 0, 0, -100000, 1, 100000);
    send_pair(0, 0, 1, 1, 0, 1, 1, 0);
    send_pair(24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555,
              24'h555555, 24'h555555, 24'haaaaaa, 24'haaaaaa);
  endtask

  initial begin
    #100ms;
    $display("segment_crossing_test_top_tb: errors");
    $finish;
  end

  initial begin
    logic [sct_pkg::TOL_W-1:0] tols[6];
    tols = '{16'd7, 16'd0, 16'hffff, 16'h8000, 16'h8001, 16'd0};
    tols[5] = $urandom_range(1, 300);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_pairs();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        set_tolerance(tols[ph]);
        if (ph <= 2) directed_pairs();
      end
      random_pairs(280);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("covered %0d segment pairs under 6 tolerance settings, %0d crossings seen",
             n_items, hits);
    if (errors == 0 && pending == 0) begin
      $display("segment_crossing_test_top_tb: clean");
    end else begin
      $display("segment_crossing_test_top_tb: errors");
    end
    $finish;
  end

endmodule
